// ===== hw/rtl/kped_pkg.sv =====
// Shared types, codes and reset values for the key press event detector.
`default_nettype none
package kped_pkg;

	typedef enum logic [2:0] {
		PH_WAIT     = 3'd0,
		PH_DEBOUNCE = 3'd1,
		PH_LONG     = 3'd2,
		PH_WINDOW   = 3'd3,
		PH_REPEAT   = 3'd4
	} kped_phase_t;

	typedef enum logic [2:0] {
		EV_CLICK        = 3'd0,
		EV_LONG         = 3'd1,
		EV_REPEAT       = 3'd2,
		EV_LONG_RELEASE = 3'd3,
		EV_DOUBLE       = 3'd4
	} kped_event_code_t;

	typedef enum logic [1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1,
		REG_REPEAT   = 2'd2,
		REG_DOUBLE   = 2'd3
	} kped_reg_t;

	typedef struct packed {
		logic [7:0]  debounce_ticks;
		logic [15:0] long_press_ticks;
		logic [7:0]  repeat_ticks;
		logic [7:0]  double_click_ticks;
	} kped_cfg_t;

	typedef struct packed {
		logic             vld;
		kped_event_code_t code;
	} kped_event_t;

	localparam logic [7:0]  DEBOUNCE_RST = 8'd2;
	localparam logic [15:0] LONG_RST     = 16'd300;
	localparam logic [7:0]  REPEAT_RST   = 8'd15;
	localparam logic [7:0]  DOUBLE_RST   = 8'd20;

endpackage
`default_nettype wire

// ===== hw/rtl/kped_lane.sv =====
// Per-key phase machine: debounce, long-press timing, release window, repeat.
`default_nettype none
module kped_lane (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               advance,
	input  wire               pressed,
	input  kped_pkg::kped_cfg_t   cfg,
	output kped_pkg::kped_event_t ev
);
	import kped_pkg::*;

	kped_phase_t phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic        done;
	logic [15:0] cnt_dec;

	always_comb begin
		done    = (cnt_q <= 16'd1);
		cnt_dec = done ? 16'd0 : cnt_q - 16'd1;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		ev.vld  = 1'b0;
		ev.code = EV_CLICK;
		case (phase_q)
			PH_WAIT: begin
				if (pressed) begin
					phase_d = PH_DEBOUNCE;
					cnt_d   = {8'd0, cfg.debounce_ticks};
				end
			end
			PH_DEBOUNCE: begin
				if (!pressed) begin
					phase_d = PH_WAIT;
					cnt_d   = {8'd0, cfg.debounce_ticks};
				end else if (done) begin
					phase_d = PH_LONG;
					cnt_d   = cfg.long_press_ticks;
				end else begin
					cnt_d = cnt_dec;
				end
			end
			PH_LONG: begin
				if (!pressed) begin
					phase_d = PH_WINDOW;
					cnt_d   = {8'd0, cfg.double_click_ticks};
				end else if (done) begin
					phase_d = PH_REPEAT;
					cnt_d   = {8'd0, cfg.repeat_ticks};
					ev.vld  = 1'b1;
					ev.code = EV_LONG;
				end else begin
					cnt_d = cnt_dec;
				end
			end
			PH_WINDOW: begin
				// window expiry wins over a press on the same tick
				if (done) begin
					phase_d = PH_WAIT;
					cnt_d   = {8'd0, cfg.debounce_ticks};
					ev.vld  = 1'b1;
					ev.code = EV_CLICK;
				end else if (pressed) begin
					phase_d = PH_WAIT;
					cnt_d   = {8'd0, cfg.debounce_ticks};
					ev.vld  = 1'b1;
					ev.code = EV_DOUBLE;
				end else begin
					cnt_d = cnt_dec;
				end
			end
			PH_REPEAT: begin
				if (!pressed) begin
					phase_d = PH_WAIT;
					cnt_d   = {8'd0, cfg.debounce_ticks};
					ev.vld  = 1'b1;
					ev.code = EV_LONG_RELEASE;
				end else if (done) begin
					cnt_d   = {8'd0, cfg.repeat_ticks};
					ev.vld  = 1'b1;
					ev.code = EV_REPEAT;
				end else begin
					cnt_d = cnt_dec;
				end
			end
			default: begin
				phase_d = PH_WAIT;
				cnt_d   = {8'd0, cfg.debounce_ticks};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			cnt_q   <= {8'd0, DEBOUNCE_RST};
		end else if (advance) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/kped_merge.sv =====
// Merge stage: holds one tick's lane events and sends them out in key order.
`default_nettype none
module kped_merge #(
	parameter int NUM_KEYS = 2,
	parameter int KEY_W    = 1
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   load,
	input  kped_pkg::kped_event_t [NUM_KEYS-1:0]  ev,
	output logic                                  load_ok,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [KEY_W-1:0]                      out_index,
	output logic [2:0]                            out_code,
	output logic                                  out_last
);
	import kped_pkg::*;

	logic [NUM_KEYS-1:0] pend_q;
	kped_event_code_t    code_q [NUM_KEYS];
	logic [NUM_KEYS-1:0] rest;
	logic [KEY_W-1:0]    sel;
	kped_event_code_t    sel_code;
	logic                pop;
	logic                out_valid_q;
	logic [KEY_W-1:0]    index_q;
	kped_event_code_t    out_code_q;
	logic                last_q;

	// pick the lowest pending key
	always_comb begin
		sel      = '0;
		sel_code = EV_CLICK;
		rest     = '0;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel      = i[KEY_W-1:0];
				sel_code = code_q[i];
				rest     = pend_q;
				rest[i]  = 1'b0;
			end
		end
	end

	assign pop     = (|pend_q) && (!out_valid_q || out_ready);
	assign load_ok = (pend_q == '0) || (pop && (rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				pend_q[i] <= ev[i].vld;
			end
		end else if (pop) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				code_q[i] <= ev[i].code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			index_q    <= sel;
			out_code_q <= sel_code;
			last_q     <= (rest == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = index_q;
	assign out_code  = out_code_q;
	assign out_last  = last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/key_press_event_detector.sv =====
// Top level of the key press event detector: register port, key lanes, merge stage.
//
//  channel   signals                              direction  meaning
//  tick      tick_valid/tick_ready, key_levels    in         one scan tick, all key levels
//  event     event_valid/event_ready, key_index,  out        one key event per transfer
//            event_code, last_of_tick
//  apb       psel penable pwrite paddr pwdata      in/out     timing registers
//            prdata pready
//
// Every lane updates in the cycle its tick is taken; the merge stage then sends one
// event per cycle while event_ready holds, at most NUM_KEYS events per tick.
// A tick is taken while the previous event still waits, once its last event leaves
// the merge buffer. Reset puts every key in wait with the reset register values.
// A stalled event side holds the merge buffer and, through it, the tick side.
`default_nettype none
module key_press_event_detector #(
	parameter int NUM_KEYS = 2
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         tick_valid,
	output logic                        tick_ready,
	input  wire  [NUM_KEYS-1:0]         key_levels,
	output logic                        event_valid,
	input  wire                         event_ready,
	output logic [(NUM_KEYS > 1 ? $clog2(NUM_KEYS) : 1)-1:0] key_index,
	output logic [2:0]                  event_code,
	output logic                        last_of_tick,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [3:0]                  paddr,
	input  wire  [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import kped_pkg::*;

	localparam int KEY_W = NUM_KEYS > 1 ? $clog2(NUM_KEYS) : 1;

	kped_cfg_t                  cfg_q;
	kped_event_t [NUM_KEYS-1:0] lane_ev;
	logic                       accept;
	logic                       load_ok;
	logic                       wr;
	kped_reg_t                  reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = kped_reg_t'(paddr[3:2]);
	assign wr      = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks     <= DEBOUNCE_RST;
			cfg_q.long_press_ticks   <= LONG_RST;
			cfg_q.repeat_ticks       <= REPEAT_RST;
			cfg_q.double_click_ticks <= DOUBLE_RST;
		end else if (wr) begin
			case (reg_sel)
				REG_DEBOUNCE: cfg_q.debounce_ticks     <= pwdata[7:0];
				REG_LONG:     cfg_q.long_press_ticks   <= pwdata[15:0];
				REG_REPEAT:   cfg_q.repeat_ticks       <= pwdata[7:0];
				REG_DOUBLE:   cfg_q.double_click_ticks <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_DEBOUNCE: prdata = {24'd0, cfg_q.debounce_ticks};
			REG_LONG:     prdata = {16'd0, cfg_q.long_press_ticks};
			REG_REPEAT:   prdata = {24'd0, cfg_q.repeat_ticks};
			REG_DOUBLE:   prdata = {24'd0, cfg_q.double_click_ticks};
			default:      prdata = 32'd0;
		endcase
	end

	assign tick_ready = load_ok;
	assign accept     = tick_valid && load_ok;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		kped_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (accept),
			.pressed (key_levels[k]),
			.cfg     (cfg_q),
			.ev      (lane_ev[k])
		);
	end

	kped_merge #(
		.NUM_KEYS (NUM_KEYS),
		.KEY_W    (KEY_W)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.ev        (lane_ev),
		.load_ok   (load_ok),
		.out_valid (event_valid),
		.out_ready (event_ready),
		.out_index (key_index),
		.out_code  (event_code),
		.out_last  (last_of_tick)
	);

endmodule
`default_nettype wire

// ===== sim/key_press_event_detector_tb.sv =====
// Self-checking testbench for the key press event detector: scan ticks in, key events out.
module key_press_event_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kped_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 10;

	// Opening scan sequence: debounce loss, click, double click, long press with repeats,
	// long-press release, and a window that runs out on a pressed tick.
	localparam logic [55:0] OPENING_TICKS = {
		2'd0, 2'd1, 2'd0, 2'd3, 2'd3, 2'd0, 2'd0, 2'd0, 2'd3, 2'd3, 2'd0, 2'd3, 2'd3, 2'd3,
		2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd1, 2'd1, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0, 2'd2, 2'd0
	};

	typedef struct packed {
		logic             key;
		kped_event_code_t code;
		logic             last;
	} key_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        tick_valid = 1'b0;
	logic        tick_ready;
	logic [1:0]  key_levels = 2'd0;
	logic        event_valid;
	logic        event_ready = 1'b0;
	logic [0:0]  key_index;
	logic [2:0]  event_code;
	logic        last_of_tick;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	logic [1:0]  scan_ticks[$];
	key_event_t  pending_events[$];
	key_event_t  next_event;

	logic [7:0]  cfg_debounce;
	logic [15:0] cfg_long;
	logic [7:0]  cfg_repeat;
	logic [7:0]  cfg_double;
	kped_phase_t lane_phase[2];
	logic [15:0] lane_count[2];

	bit          lane_bits[2][0:1023];
	bit          gaps_on = 1'b0;
	bit          draining = 1'b0;
	int          tick_gap = 0;
	int          ready_stall = 0;
	int          idle_cycles = 0;
	int          mismatches = 0;

	key_press_event_detector #(
		.NUM_KEYS(2)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_ready(tick_ready),
		.key_levels(key_levels),
		.event_valid(event_valid),
		.event_ready(event_ready),
		.key_index(key_index),
		.event_code(event_code),
		.last_of_tick(last_of_tick),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly back to back, sometimes a short gap, now and then a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// A zero count behaves as a count of one.
	function automatic int span(int v);
		return (v == 0) ? 1 : v;
	endfunction

	// Decrement a key's counter; true on the tick that ends its phase.
	function automatic bit run_out(int k);
		if (lane_count[k] <= 16'd1) begin
			lane_count[k] = 16'd0;
			return 1'b1;
		end
		lane_count[k] = lane_count[k] - 16'd1;
		return 1'b0;
	endfunction

	function automatic void rearm(int k);
		lane_phase[k] = PH_WAIT;
		lane_count[k] = {8'd0, cfg_debounce};
	endfunction

	// Step every key for one scan tick and queue the events it raises, in key order.
	task automatic advance_keys(input logic [1:0] levels);
		key_event_t       found[2];
		int               n;
		bit               fire;
		kped_event_code_t code;
		n = 0;
		for (int k = 0; k < 2; k++) begin
			fire = 1'b0;
			code = EV_CLICK;
			case (lane_phase[k])
			PH_WAIT: begin
				if (levels[k]) begin
					lane_phase[k] = PH_DEBOUNCE;
					lane_count[k] = {8'd0, cfg_debounce};
				end
			end
			PH_DEBOUNCE: begin
				if (!levels[k])
					rearm(k);
				else if (run_out(k)) begin
					lane_phase[k] = PH_LONG;
					lane_count[k] = cfg_long;
				end
			end
			PH_LONG: begin
				if (!levels[k]) begin
					lane_phase[k] = PH_WINDOW;
					lane_count[k] = {8'd0, cfg_double};
				end else if (run_out(k)) begin
					lane_phase[k] = PH_REPEAT;
					lane_count[k] = {8'd0, cfg_repeat};
					fire = 1'b1;
					code = EV_LONG;
				end
			end
			PH_WINDOW: begin
				// window expiry wins over a press on the same tick
				if (run_out(k)) begin
					fire = 1'b1;
					code = EV_CLICK;
					rearm(k);
				end else if (levels[k]) begin
					fire = 1'b1;
					code = EV_DOUBLE;
					rearm(k);
				end
			end
			PH_REPEAT: begin
				if (!levels[k]) begin
					fire = 1'b1;
					code = EV_LONG_RELEASE;
					rearm(k);
				end else if (run_out(k)) begin
					lane_count[k] = {8'd0, cfg_repeat};
					fire = 1'b1;
					code = EV_REPEAT;
				end
			end
			default: rearm(k);
			endcase
			if (fire) begin
				found[n] = {k[0], code, 1'b0};
				n++;
			end
		end
		if (n > 0)
			found[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_events.push_back(found[i]);
	endtask

	// Tick driver: hold the item until the transfer, then insert a gap or send the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
			key_levels <= 2'd0;
			tick_gap = 0;
			draining = 1'b0;
		end else begin
			if (tick_valid && tick_ready) begin
				advance_keys(key_levels);
				if ($urandom_range(0, 149) == 0)
					draining = 1'b1;
			end
			if (draining && pending_events.size() == 0)
				draining = 1'b0;
			if (!tick_valid || tick_ready) begin
				if (tick_gap > 0) begin
					tick_gap--;
					tick_valid <= 1'b0;
				end else if (!draining && scan_ticks.size() > 0) begin
					tick_valid <= 1'b1;
					key_levels <= scan_ticks.pop_front();
					tick_gap = gaps_on ? pick_gap() : 0;
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	// Event monitor: check each transfer against the oldest expectation, stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_ready <= 1'b0;
			ready_stall = 0;
		end else begin
			if (event_valid && event_ready) begin
				if (pending_events.size() == 0) begin
					$error("unexpected event: key_index %0d event_code %0d last_of_tick %0d",
						key_index, event_code, last_of_tick);
					mismatches++;
				end else begin
					next_event = pending_events.pop_front();
					if (key_index !== next_event.key) begin
						$error("key_index: expected %0d, got %0d", next_event.key, key_index);
						mismatches++;
					end
					if (event_code !== next_event.code) begin
						$error("event_code: expected %0d, got %0d", next_event.code, event_code);
						mismatches++;
					end
					if (last_of_tick !== next_event.last) begin
						$error("last_of_tick: expected %0d, got %0d", next_event.last,
							last_of_tick);
						mismatches++;
					end
				end
			end
			if (ready_stall > 0) begin
				ready_stall--;
				event_ready <= 1'b0;
			end else begin
				event_ready <= 1'b1;
				if (gaps_on && $urandom_range(0, 3) == 0)
					ready_stall = pick_gap();
			end
		end
	end

	// Abort when nothing moves on any port for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_valid && tick_ready) || (event_valid && event_ready) ||
				(psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[key_press_event_detector] ERROR");
				$finish;
			end
		end
	end

	// One register access: setup cycle, then access until pready; reads are checked.
	task automatic reg_access(input kped_reg_t idx, input logic [31:0] value, input bit wr);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wr ? value : 32'd0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (wr) begin
			case (idx)
			REG_DEBOUNCE: cfg_debounce = value[7:0];
			REG_LONG:     cfg_long = value[15:0];
			REG_REPEAT:   cfg_repeat = value[7:0];
			REG_DOUBLE:   cfg_double = value[7:0];
			default: ;
			endcase
		end else if (prdata !== value) begin
			$error("prdata: expected %0d, got %0d", value, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Block until every tick is sent and every event is back, then let the lanes settle.
	task automatic wait_idle();
		while (scan_ticks.size() != 0 || tick_valid || pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] db, input logic [15:0] lp, input logic [7:0] rp,
		input logic [7:0] dc, input bit gaps);
		wait_idle();
		reg_access(REG_DEBOUNCE, {24'd0, db}, 1'b1);
		reg_access(REG_LONG, {16'd0, lp}, 1'b1);
		reg_access(REG_REPEAT, {24'd0, rp}, 1'b1);
		reg_access(REG_DOUBLE, {24'd0, dc}, 1'b1);
		reg_access(REG_LONG, {16'd0, lp}, 1'b0);
		reg_access(REG_DOUBLE, {24'd0, dc}, 1'b0);
		gaps_on = gaps;
	endtask

	// Build n ticks from press/release gestures per key, with some noise mixed in.
	task automatic queue_scan(input int n);
		int pos, p, r, pick, db, lp, rp, dc;
		db = span(int'(cfg_debounce));
		lp = span(int'(cfg_long));
		rp = span(int'(cfg_repeat));
		dc = span(int'(cfg_double));
		for (int k = 0; k < 2; k++) begin
			pos = 0;
			while (pos < n) begin
				pick = $urandom_range(0, 9);
				if (pick >= 7) begin
					r = $urandom_range(1, 6);
					for (int i = 0; i < r && pos < n; i++) begin
						lane_bits[k][pos] = 1'($urandom_range(0, 1));
						pos++;
					end
				end else begin
					if (pick >= 4 && lp <= 200)
						p = 1 + db + lp + $urandom_range(0, 3 * rp + 2);
					else
						p = $urandom_range(1, 1 + db + ((lp - 1 < 12) ? lp - 1 : 12));
					// short releases set up double clicks, long ones let the window run out
					if ($urandom_range(0, 1) == 0)
						r = $urandom_range(1, dc);
					else
						r = $urandom_range(dc, dc + 4);
					for (int i = 0; i < p && pos < n; i++) begin
						lane_bits[k][pos] = 1'b1;
						pos++;
					end
					for (int i = 0; i < r && pos < n; i++) begin
						lane_bits[k][pos] = 1'b0;
						pos++;
					end
				end
			end
		end
		for (int i = 0; i < n; i++)
			scan_ticks.push_back({lane_bits[1][i], lane_bits[0][i]});
	endtask

	initial begin
		cfg_debounce = DEBOUNCE_RST;
		cfg_long = LONG_RST;
		cfg_repeat = REPEAT_RST;
		cfg_double = DOUBLE_RST;
		for (int k = 0; k < 2; k++)
			rearm(k);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		reg_access(REG_DEBOUNCE, {24'd0, DEBOUNCE_RST}, 1'b0);
		reg_access(REG_LONG, {16'd0, LONG_RST}, 1'b0);
		reg_access(REG_REPEAT, {24'd0, REPEAT_RST}, 1'b0);
		reg_access(REG_DOUBLE, {24'd0, DOUBLE_RST}, 1'b0);

		configure(8'd1, 16'd3, 8'd2, 8'd2, 1'b1);
		for (int i = 0; i < 28; i++)
			scan_ticks.push_back(OPENING_TICKS[2 * (27 - i) +: 2]);

		configure(8'd1, 16'd1, 8'd1, 8'd2, 1'b1);
		queue_scan(200);

		configure(8'($urandom_range(1, 4)), 16'($urandom_range(2, 20)),
			8'($urandom_range(1, 5)), 8'($urandom_range(2, 12)), 1'b1);
		queue_scan(250);

		configure(8'd255, 16'd65535, 8'd255, 8'd255, 1'b1);
		queue_scan(150);

		// zero counts end their phase on the first counting tick
		configure(8'd0, 16'd0, 8'd0, 8'd0, 1'b1);
		queue_scan(150);

		configure(8'($urandom_range(1, 4)), 16'($urandom_range(2, 20)),
			8'($urandom_range(1, 5)), 8'($urandom_range(2, 12)), 1'b0);
		queue_scan(250);

		configure(DEBOUNCE_RST, LONG_RST, REPEAT_RST, DOUBLE_RST, 1'b1);
		queue_scan(100);

		wait_idle();
		if (mismatches == 0)
			$display("[key_press_event_detector] OK");
		else
			$display("[key_press_event_detector] ERROR");
		$finish;
	end

endmodule
